// ----- sv/cmpfm_pkg.sv -----
// Shared constants, types and helpers for the cube-map face mapper.
// No dependencies; used by every module of the block.
package cmpfm_pkg;

   localparam int COORD_BITS_DEF = 14;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int SIZE_W     = 16;
   localparam int MID_W      = 14;
   localparam int START_W    = 18;
   localparam int NORM_W     = 16;
   localparam int OUT_FRAC   = 8;
   localparam int FACE_W     = 3;
   localparam int FACE_COUNT = 6;
   localparam int CSR_W      = 48;
   localparam int CSR_IDX_W  = 3;

   localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd0;
   localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd1;
   localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd2;
   localparam logic [FACE_W-1:0] FACE_TOP    = 3'd3;
   localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd4;
   localparam logic [FACE_W-1:0] FACE_BACK   = 3'd5;
   localparam logic [FACE_W-1:0] FACE_BLACK  = 3'd6;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH_A  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH_B  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT_A = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT_B = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MID_COL  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MID_ROW  = 3'd5;

   localparam logic [CSR_W-1:0] TABLE_RESET = 48'h0400_0400_0400;
   localparam logic [MID_W-1:0] MID_RESET   = 14'd1024;

   typedef struct packed {
      logic [FACE_COUNT-1:0][START_W-1:0] xs;
      logic [FACE_COUNT-1:0][START_W-1:0] ys;
      logic [FACE_COUNT-1:0][SIZE_W-1:0]  w;
      logic [FACE_COUNT-1:0][SIZE_W-1:0]  h;
   } geom_type;

   // centring offset, zero when the face overhangs its span
   function automatic logic [SIZE_W-1:0] centre(input logic [MID_W-1:0] span,
                                                input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] diff;
      diff = SIZE_W'(span) - size;
      return (SIZE_W'(span) > size) ? (diff >> 1) : '0;
   endfunction

   // one restoring division step: {quotient bit, new remainder}
   function automatic logic [SIZE_W:0] div_step(input logic [SIZE_W-1:0] rem,
                                                input logic [SIZE_W-1:0] dvs);
      logic [SIZE_W:0] r2;
      logic [SIZE_W:0] d2;
      r2 = {rem, 1'b0};
      d2 = {1'b0, dvs};
      if (r2 >= d2) begin
         r2 = r2 - d2;
         return {1'b1, r2[SIZE_W-1:0]};
      end
      return {1'b0, r2[SIZE_W-1:0]};
   endfunction

endpackage

// ----- sv/cube_map_pixel_face_mapper_core.sv -----
// Cube-map packed-frame coordinate mapper, top level.
// Depends on cmpfm_pkg, cmpfm_geom and cmpfm_divider.
//
// Input beats (req_*) carry either a frame pixel (kind 0), which is mapped to
// its face and a normalised Q0.FRAC position, or a face and a normalised
// position (kind 1), which is mapped to a COORD_BITS.8 frame coordinate. Every input
// beat gives exactly one response beat (rsp_*), in order.
// Face sizes and the middle column and row sizes sit in registers written
// through csr_we / csr_index / csr_wdata; write them only while idle.
// From acceptance to rsp_valid a beat passes through the input register, a face
// search and multiply stage, one restoring division stage per quotient bit, and
// the output register.
// One beat is accepted per cycle while the receiver does not stall the output,
// as the division pipeline takes a new item every cycle while enabled.
// An output register plus one skid entry sit at the end; when the receiver
// stalls, the skid entry fills and then the whole pipeline holds, dropping
// req_ready, until rsp_ready returns. Nothing is lost or repeated.
// Synchronous reset empties the pipeline and restores the size registers to
// 1024 in every slot.
module cube_map_pixel_face_mapper_core #(
   parameter int COORD_BITS = cmpfm_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = cmpfm_pkg::FRAC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_kind,
   input  logic [COORD_BITS-1:0]                   req_pixel_x,
   input  logic [COORD_BITS-1:0]                   req_pixel_y,
   input  logic [cmpfm_pkg::FACE_W-1:0]            req_face_in,
   input  logic [cmpfm_pkg::NORM_W-1:0]            req_norm_x_in,
   input  logic [cmpfm_pkg::NORM_W-1:0]            req_norm_y_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [cmpfm_pkg::FACE_W-1:0]            rsp_face_id,
   output logic [cmpfm_pkg::NORM_W-1:0]            rsp_norm_x_out,
   output logic [cmpfm_pkg::NORM_W-1:0]            rsp_norm_y_out,
   output logic [COORD_BITS+cmpfm_pkg::OUT_FRAC-1:0] rsp_frame_x,
   output logic [COORD_BITS+cmpfm_pkg::OUT_FRAC-1:0] rsp_frame_y,
   output logic                                    rsp_bad_face,
   input  logic                                    csr_we,
   input  logic [cmpfm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [cmpfm_pkg::CSR_W-1:0]             csr_wdata
);
   import cmpfm_pkg::*;

   localparam int FW     = COORD_BITS + OUT_FRAC;
   localparam int PROD_W = SIZE_W + NORM_W;
   localparam int HI_W   = SIZE_W + OUT_FRAC;
   localparam int SUM_W  = START_W + OUT_FRAC + 1;
   localparam int SHIFT  = FRAC_BITS - OUT_FRAC;
   localparam int SIDE_W = FACE_W + 2 + 2 * NORM_W + 2 * FW;

   typedef struct packed {
      logic [FACE_W-1:0] face;
      logic [NORM_W-1:0] nx;
      logic [NORM_W-1:0] ny;
      logic [FW-1:0]     fx;
      logic [FW-1:0]     fy;
      logic              bad;
   } rsp_type;

   typedef struct packed {
      logic [FACE_W-1:0] face;
      logic              use_q;
      logic              bad;
      logic [NORM_W-1:0] ex;
      logic [NORM_W-1:0] ey;
      logic [FW-1:0]     fx;
      logic [FW-1:0]     fy;
   } side_type;

   // ---------------- size registers
   logic [CSR_W-1:0] width_a_ff, width_b_ff, height_a_ff, height_b_ff;
   logic [MID_W-1:0] mid_col_ff, mid_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_a_ff  <= TABLE_RESET;
         width_b_ff  <= TABLE_RESET;
         height_a_ff <= TABLE_RESET;
         height_b_ff <= TABLE_RESET;
         mid_col_ff  <= MID_RESET;
         mid_row_ff  <= MID_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_WIDTH_A:  width_a_ff  <= csr_wdata;
            REG_WIDTH_B:  width_b_ff  <= csr_wdata;
            REG_HEIGHT_A: height_a_ff <= csr_wdata;
            REG_HEIGHT_B: height_b_ff <= csr_wdata;
            REG_MID_COL:  mid_col_ff  <= csr_wdata[MID_W-1:0];
            REG_MID_ROW:  mid_row_ff  <= csr_wdata[MID_W-1:0];
            default: ;
         endcase
      end
   end

   geom_type geom_in;

   cmpfm_geom u_geom (
      .width_a  (width_a_ff),
      .width_b  (width_b_ff),
      .height_a (height_a_ff),
      .height_b (height_b_ff),
      .mid_col  (mid_col_ff),
      .mid_row  (mid_row_ff),
      .geom     (geom_in)
   );

   // ---------------- pipeline hold and output skid
   logic    en;
   logic    skid_v_ff;
   rsp_type skid_ff;
   logic    out_v_ff;
   rsp_type out_ff;

   assign en        = !skid_v_ff;
   assign req_ready = en;

   // ---------------- stage 1: input register with geometry
   logic                  s1_v_ff;
   logic                  s1_kind_ff;
   logic [COORD_BITS-1:0] s1_px_ff, s1_py_ff;
   logic [FACE_W-1:0]     s1_face_ff;
   logic [NORM_W-1:0]     s1_nx_ff, s1_ny_ff;
   geom_type              s1_geom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_kind_ff <= req_kind;
         s1_px_ff   <= req_pixel_x;
         s1_py_ff   <= req_pixel_y;
         s1_face_ff <= req_face_in;
         s1_nx_ff   <= req_norm_x_in;
         s1_ny_ff   <= req_norm_y_in;
         s1_geom_ff <= geom_in;
      end
   end

   // ---------------- stage 2: face search, scaling multiply
   logic [FACE_COUNT-1:0] hit;
   logic [START_W:0]      px_ext, py_ext;
   logic [FACE_W-1:0]     s2_face_in;
   logic                  s2_bad_in;
   logic [SIZE_W-1:0]     s2_rx_in, s2_ry_in, s2_dx_in, s2_dy_in;
   logic [SIZE_W-1:0]     s2_sx_in, s2_sy_in;
   logic [START_W-1:0]    s2_stx_in, s2_sty_in;
   logic [FACE_W-1:0]     fidx;
   logic [START_W:0]      dx_full, dy_full;
   logic [SIZE_W-1:0]     k1_sx, k1_sy;

   always_comb begin
      px_ext = (START_W+1)'(s1_px_ff);
      py_ext = (START_W+1)'(s1_py_ff);
      for (int f = 0; f < FACE_COUNT; f++) begin
         hit[f] = (px_ext >= (START_W+1)'(s1_geom_ff.xs[f]))
               && (px_ext < (START_W+1)'(s1_geom_ff.xs[f])
                            + (START_W+1)'(s1_geom_ff.w[f]))
               && (py_ext >= (START_W+1)'(s1_geom_ff.ys[f]))
               && (py_ext < (START_W+1)'(s1_geom_ff.ys[f])
                            + (START_W+1)'(s1_geom_ff.h[f]));
      end

      // multiplier operands straight from the face code, off the search path
      k1_sx = (s1_face_ff < FACE_BLACK) ? s1_geom_ff.w[s1_face_ff] : '0;
      k1_sy = (s1_face_ff < FACE_BLACK) ? s1_geom_ff.h[s1_face_ff] : '0;

      fidx = FACE_BLACK;
      if (hit[FACE_LEFT])        fidx = FACE_LEFT;
      else if (hit[FACE_TOP])    fidx = FACE_TOP;
      else if (hit[FACE_FRONT])  fidx = FACE_FRONT;
      else if (hit[FACE_BOTTOM]) fidx = FACE_BOTTOM;
      else if (hit[FACE_RIGHT])  fidx = FACE_RIGHT;
      else if (hit[FACE_BACK])   fidx = FACE_BACK;
      if (s1_kind_ff) begin
         fidx = (s1_face_ff < FACE_BLACK) ? s1_face_ff : FACE_BLACK;
      end

      s2_face_in = fidx;
      s2_bad_in  = s1_kind_ff && (fidx == FACE_BLACK);
      s2_rx_in   = '0;
      s2_ry_in   = '0;
      s2_dx_in   = '0;
      s2_dy_in   = '0;
      s2_sx_in   = '0;
      s2_sy_in   = '0;
      s2_stx_in  = '0;
      s2_sty_in  = '0;
      dx_full    = '0;
      dy_full    = '0;
      if (fidx != FACE_BLACK) begin
         s2_sx_in  = s1_geom_ff.w[fidx];
         s2_sy_in  = s1_geom_ff.h[fidx];
         s2_stx_in = s1_geom_ff.xs[fidx];
         s2_sty_in = s1_geom_ff.ys[fidx];
         if (!s1_kind_ff) begin
            // inside the face the offset stays below the face size
            dx_full  = px_ext - (START_W+1)'(s1_geom_ff.xs[fidx]);
            dy_full  = py_ext - (START_W+1)'(s1_geom_ff.ys[fidx]);
            s2_rx_in = dx_full[SIZE_W-1:0];
            s2_ry_in = dy_full[SIZE_W-1:0];
            s2_dx_in = s1_geom_ff.w[fidx];
            s2_dy_in = s1_geom_ff.h[fidx];
         end
      end
   end

   logic               s2_v_ff;
   logic               s2_kind_ff;
   logic [FACE_W-1:0]  s2_face_ff;
   logic               s2_bad_ff;
   logic [SIZE_W-1:0]  s2_rx_ff, s2_ry_ff, s2_dx_ff, s2_dy_ff;
   logic [SIZE_W-1:0]  s2_sx_ff, s2_sy_ff;
   logic [START_W-1:0] s2_stx_ff, s2_sty_ff;
   logic [PROD_W-1:0]  s2_px_ff, s2_py_ff;
   logic [NORM_W-1:0]  s2_nx_ff, s2_ny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_kind_ff <= s1_kind_ff;
         s2_face_ff <= s2_face_in;
         s2_bad_ff  <= s2_bad_in;
         s2_rx_ff   <= s2_rx_in;
         s2_ry_ff   <= s2_ry_in;
         s2_dx_ff   <= s2_dx_in;
         s2_dy_ff   <= s2_dy_in;
         s2_sx_ff   <= s2_sx_in;
         s2_sy_ff   <= s2_sy_in;
         s2_stx_ff  <= s2_stx_in;
         s2_sty_ff  <= s2_sty_in;
         s2_px_ff   <= PROD_W'(k1_sx) * PROD_W'(s1_nx_ff);
         s2_py_ff   <= PROD_W'(k1_sy) * PROD_W'(s1_ny_ff);
         s2_nx_ff   <= s1_nx_ff;
         s2_ny_ff   <= s1_ny_ff;
      end
   end

   // ---------------- stage 3: clamp and place, then into the divider
   function automatic logic [FW-1:0] place(input logic [PROD_W-1:0] prod,
                                           input logic [SIZE_W-1:0] size,
                                           input logic [START_W-1:0] start);
      logic [PROD_W-1:0] v;
      logic [HI_W-1:0]   hi;
      logic [SUM_W-1:0]  sum;
      v  = prod >> SHIFT;
      hi = (size != '0) ? (HI_W'(size - 1'b1) << OUT_FRAC) : '0;
      if (v > PROD_W'(hi)) v = PROD_W'(hi);
      if (v < (PROD_W'(1) << OUT_FRAC)) v = PROD_W'(1) << OUT_FRAC;
      sum = SUM_W'(v) + (SUM_W'(start) << OUT_FRAC);
      return sum[FW-1:0];
   endfunction

   side_type side_in;
   logic     kind1_ok;

   always_comb begin
      kind1_ok      = s2_kind_ff && !s2_bad_ff;
      side_in.face  = s2_face_ff;
      side_in.use_q = !s2_kind_ff && (s2_face_ff != FACE_BLACK);
      side_in.bad   = s2_bad_ff;
      side_in.ex    = kind1_ok ? s2_nx_ff : '0;
      side_in.ey    = kind1_ok ? s2_ny_ff : '0;
      side_in.fx    = kind1_ok ? place(s2_px_ff, s2_sx_ff, s2_stx_ff) : '0;
      side_in.fy    = kind1_ok ? place(s2_py_ff, s2_sy_ff, s2_sty_ff) : '0;
   end

   logic                 dv_valid;
   logic [FRAC_BITS-1:0] dv_qx, dv_qy;
   logic [SIDE_W-1:0]    dv_side_bits;
   side_type             dv_side;

   cmpfm_divider #(
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_v_ff),
      .in_rem_x  (s2_rx_ff),
      .in_rem_y  (s2_ry_ff),
      .in_dvs_x  (s2_dx_ff),
      .in_dvs_y  (s2_dy_ff),
      .in_side   (side_in),
      .out_valid (dv_valid),
      .out_q_x   (dv_qx),
      .out_q_y   (dv_qy),
      .out_side  (dv_side_bits)
   );

   assign dv_side = dv_side_bits;

   rsp_type last_rsp;

   always_comb begin
      last_rsp.face = dv_side.face;
      last_rsp.nx   = dv_side.use_q ? NORM_W'(dv_qx) : dv_side.ex;
      last_rsp.ny   = dv_side.use_q ? NORM_W'(dv_qy) : dv_side.ey;
      last_rsp.fx   = dv_side.fx;
      last_rsp.fy   = dv_side.fy;
      last_rsp.bad  = dv_side.bad;
   end

   // ---------------- output register and skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_ready) begin
         out_v_ff  <= skid_v_ff ? 1'b1 : dv_valid;
         skid_v_ff <= 1'b0;
      end else if (dv_valid && en) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_ready) begin
         out_ff <= skid_v_ff ? skid_ff : last_rsp;
      end else if (dv_valid && en) begin
         skid_ff <= last_rsp;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_face_id    = out_ff.face;
   assign rsp_norm_x_out = out_ff.nx;
   assign rsp_norm_y_out = out_ff.ny;
   assign rsp_frame_x    = out_ff.fx;
   assign rsp_frame_y    = out_ff.fy;
   assign rsp_bad_face   = out_ff.bad;

endmodule

// ----- sv/cmpfm_geom.sv -----
// Face sizes and start offsets of the packed frame, from the size registers.
// Depends on cmpfm_pkg.
module cmpfm_geom (
   input  logic [cmpfm_pkg::CSR_W-1:0] width_a,
   input  logic [cmpfm_pkg::CSR_W-1:0] width_b,
   input  logic [cmpfm_pkg::CSR_W-1:0] height_a,
   input  logic [cmpfm_pkg::CSR_W-1:0] height_b,
   input  logic [cmpfm_pkg::MID_W-1:0] mid_col,
   input  logic [cmpfm_pkg::MID_W-1:0] mid_row,
   output cmpfm_pkg::geom_type         geom
);
   import cmpfm_pkg::*;

   logic [SIZE_W-1:0] w [FACE_COUNT];
   logic [SIZE_W-1:0] h [FACE_COUNT];
   logic [START_W-1:0] l_ext;
   logic [START_W-1:0] t_ext;

   always_comb begin
      w[FACE_FRONT]  = width_a[15:0];
      w[FACE_LEFT]   = width_a[31:16];
      w[FACE_RIGHT]  = width_a[47:32];
      w[FACE_TOP]    = width_b[15:0];
      w[FACE_BOTTOM] = width_b[31:16];
      w[FACE_BACK]   = width_b[47:32];
      h[FACE_FRONT]  = height_a[15:0];
      h[FACE_LEFT]   = height_a[31:16];
      h[FACE_RIGHT]  = height_a[47:32];
      h[FACE_TOP]    = height_b[15:0];
      h[FACE_BOTTOM] = height_b[31:16];
      h[FACE_BACK]   = height_b[47:32];
      l_ext = START_W'(w[FACE_LEFT]);
      t_ext = START_W'(h[FACE_TOP]);

      for (int f = 0; f < FACE_COUNT; f++) begin
         geom.w[f] = w[f];
         geom.h[f] = h[f];
      end

      geom.xs[FACE_LEFT]   = '0;
      geom.xs[FACE_FRONT]  = l_ext;
      geom.xs[FACE_RIGHT]  = l_ext + START_W'(mid_col);
      geom.xs[FACE_TOP]    = l_ext + START_W'(centre(mid_col, w[FACE_TOP]));
      geom.xs[FACE_BOTTOM] = l_ext + START_W'(centre(mid_col, w[FACE_BOTTOM]));
      geom.xs[FACE_BACK]   = l_ext + START_W'(mid_col) + START_W'(w[FACE_RIGHT]);

      geom.ys[FACE_TOP]    = '0;
      geom.ys[FACE_BOTTOM] = t_ext + START_W'(mid_row);
      geom.ys[FACE_FRONT]  = t_ext + START_W'(centre(mid_row, h[FACE_FRONT]));
      geom.ys[FACE_LEFT]   = t_ext + START_W'(centre(mid_row, h[FACE_LEFT]));
      geom.ys[FACE_RIGHT]  = t_ext + START_W'(centre(mid_row, h[FACE_RIGHT]));
      geom.ys[FACE_BACK]   = t_ext + START_W'(centre(mid_row, h[FACE_BACK]));
   end

endmodule

// ----- sv/cmpfm_divider.sv -----
// Two-lane pipelined restoring divider, one quotient bit per stage,
// with a side payload riding along. Depends on cmpfm_pkg.
module cmpfm_divider #(
   parameter int FRAC_BITS = cmpfm_pkg::FRAC_BITS_DEF,
   parameter int SIDE_W    = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [cmpfm_pkg::SIZE_W-1:0] in_rem_x,
   input  logic [cmpfm_pkg::SIZE_W-1:0] in_rem_y,
   input  logic [cmpfm_pkg::SIZE_W-1:0] in_dvs_x,
   input  logic [cmpfm_pkg::SIZE_W-1:0] in_dvs_y,
   input  logic [SIDE_W-1:0]            in_side,
   output logic                         out_valid,
   output logic [FRAC_BITS-1:0]         out_q_x,
   output logic [FRAC_BITS-1:0]         out_q_y,
   output logic [SIDE_W-1:0]            out_side
);
   import cmpfm_pkg::*;

   logic                 v_ff    [FRAC_BITS];
   logic [SIZE_W-1:0]    rx_ff   [FRAC_BITS];
   logic [SIZE_W-1:0]    ry_ff   [FRAC_BITS];
   logic [SIZE_W-1:0]    dx_ff   [FRAC_BITS];
   logic [SIZE_W-1:0]    dy_ff   [FRAC_BITS];
   logic [FRAC_BITS-1:0] qx_ff   [FRAC_BITS];
   logic [FRAC_BITS-1:0] qy_ff   [FRAC_BITS];
   logic [SIDE_W-1:0]    side_ff [FRAC_BITS];

   for (genvar i = 0; i < FRAC_BITS; i++) begin : g_stage
      logic                 v_src;
      logic [SIZE_W-1:0]    rx_src, ry_src, dx_src, dy_src;
      logic [FRAC_BITS-1:0] qx_src, qy_src;
      logic [SIDE_W-1:0]    side_src;
      logic [SIZE_W:0]      stx, sty;

      if (i == 0) begin : g_head
         assign v_src    = in_valid;
         assign rx_src   = in_rem_x;
         assign ry_src   = in_rem_y;
         assign dx_src   = in_dvs_x;
         assign dy_src   = in_dvs_y;
         assign qx_src   = '0;
         assign qy_src   = '0;
         assign side_src = in_side;
      end else begin : g_body
         assign v_src    = v_ff[i-1];
         assign rx_src   = rx_ff[i-1];
         assign ry_src   = ry_ff[i-1];
         assign dx_src   = dx_ff[i-1];
         assign dy_src   = dy_ff[i-1];
         assign qx_src   = qx_ff[i-1];
         assign qy_src   = qy_ff[i-1];
         assign side_src = side_ff[i-1];
      end

      assign stx = div_step(rx_src, dx_src);
      assign sty = div_step(ry_src, dy_src);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rx_ff[i]   <= stx[SIZE_W-1:0];
            ry_ff[i]   <= sty[SIZE_W-1:0];
            dx_ff[i]   <= dx_src;
            dy_ff[i]   <= dy_src;
            qx_ff[i]   <= {qx_src[FRAC_BITS-2:0], stx[SIZE_W]};
            qy_ff[i]   <= {qy_src[FRAC_BITS-2:0], sty[SIZE_W]};
            side_ff[i] <= side_src;
         end
      end
   end

   assign out_valid = v_ff[FRAC_BITS-1];
   assign out_q_x   = qx_ff[FRAC_BITS-1];
   assign out_q_y   = qy_ff[FRAC_BITS-1];
   assign out_side  = side_ff[FRAC_BITS-1];

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for cube_map_pixel_face_mapper_core.
// Depends on cmpfm_pkg and the RTL of the block; a scoreboard class predicts each
// beat from its own copy of the size registers and checks responses in order.
`timescale 1ns / 100ps

module tb;
   import cmpfm_pkg::*;

   typedef struct {
      bit        kind;
      bit [13:0] px;
      bit [13:0] py;
      bit [2:0]  face;
      bit [15:0] nx;
      bit [15:0] ny;
   } map_req_t;

   typedef struct {
      bit [2:0]  face;
      bit [15:0] nx;
      bit [15:0] ny;
      bit [21:0] fx;
      bit [21:0] fy;
      bit        bad;
   } map_rsp_t;

   localparam logic [FACE_W-1:0] SEARCH_ORDER [6] =
      '{FACE_LEFT, FACE_TOP, FACE_FRONT, FACE_BOTTOM, FACE_RIGHT, FACE_BACK};

   class face_map_scoreboard;
      bit [47:0] wtab_a, wtab_b, htab_a, htab_b;
      bit [13:0] mid_col, mid_row;
      map_rsp_t  pending_rsp [$];
      int        errors;

      function new();
         wtab_a = TABLE_RESET; wtab_b = TABLE_RESET;
         htab_a = TABLE_RESET; htab_b = TABLE_RESET;
         mid_col = MID_RESET;  mid_row = MID_RESET;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, bit [47:0] val);
         case (idx)
            REG_WIDTH_A:  wtab_a = val;
            REG_WIDTH_B:  wtab_b = val;
            REG_HEIGHT_A: htab_a = val;
            REG_HEIGHT_B: htab_b = val;
            REG_MID_COL:  mid_col = val[13:0];
            REG_MID_ROW:  mid_row = val[13:0];
            default: ;
         endcase
      endfunction

      function longint unsigned fw(logic [2:0] f);
         return f < 3 ? (wtab_a >> (16 * f)) & 16'hFFFF : (wtab_b >> (16 * (f - 3))) & 16'hFFFF;
      endfunction

      function longint unsigned fh(logic [2:0] f);
         return f < 3 ? (htab_a >> (16 * f)) & 16'hFFFF : (htab_b >> (16 * (f - 3))) & 16'hFFFF;
      endfunction

      function longint unsigned centring(longint unsigned span, longint unsigned sz);
         return span > sz ? (span - sz) / 2 : 0;
      endfunction

      function longint unsigned xs_of(logic [2:0] f);
         case (f)
            FACE_FRONT:  return fw(FACE_LEFT);
            FACE_LEFT:   return 0;
            FACE_RIGHT:  return fw(FACE_LEFT) + mid_col;
            FACE_TOP:    return fw(FACE_LEFT) + centring(mid_col, fw(FACE_TOP));
            FACE_BOTTOM: return fw(FACE_LEFT) + centring(mid_col, fw(FACE_BOTTOM));
            default:     return fw(FACE_LEFT) + mid_col + fw(FACE_RIGHT);
         endcase
      endfunction

      function longint unsigned ys_of(logic [2:0] f);
         case (f)
            FACE_TOP:    return 0;
            FACE_BOTTOM: return fh(FACE_TOP) + mid_row;
            default:     return fh(FACE_TOP) + centring(mid_row, fh(f));
         endcase
      endfunction

      // size * norm in 16.8, held within [1.0, (size-1).0], then offset by the start
      function bit [21:0] to_frame(longint unsigned sz, longint unsigned nrm,
                                   longint unsigned start);
         longint unsigned v, hi;
         v  = (sz * nrm) >> 8;
         hi = sz > 0 ? (sz - 1) << 8 : 0;
         if (v > hi) v = hi;
         if (v < 256) v = 256;
         v += start << 8;
         return v[21:0];
      endfunction

      function longint unsigned frame_w();
         return fw(FACE_LEFT) + mid_col + fw(FACE_RIGHT) + fw(FACE_BACK);
      endfunction

      function longint unsigned frame_h();
         return fh(FACE_TOP) + mid_row + fh(FACE_BOTTOM);
      endfunction

      function void note_req(map_req_t r);
         map_rsp_t e;
         longint unsigned x0, y0, w, h;
         e = '{FACE_BLACK, 0, 0, 0, 0, 0};
         if (!r.kind) begin
            foreach (SEARCH_ORDER[k]) begin
               x0 = xs_of(SEARCH_ORDER[k]); y0 = ys_of(SEARCH_ORDER[k]);
               w  = fw(SEARCH_ORDER[k]);    h  = fh(SEARCH_ORDER[k]);
               if (r.px >= x0 && r.px < x0 + w && r.py >= y0 && r.py < y0 + h) begin
                  e.face = SEARCH_ORDER[k];
                  e.nx = 16'((((r.px - x0) << 16) / w));
                  e.ny = 16'((((r.py - y0) << 16) / h));
                  break;
               end
            end
         end else if (r.face < FACE_BLACK) begin
            e.face = r.face;
            e.nx = r.nx;
            e.ny = r.ny;
            e.fx = to_frame(fw(r.face), r.nx, xs_of(r.face));
            e.fy = to_frame(fh(r.face), r.ny, ys_of(r.face));
         end else begin
            e.bad = 1;
         end
         pending_rsp.push_back(e);
      endfunction

      function void check_rsp(map_rsp_t a);
         map_rsp_t e;
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response beat face=%0d", a.face);
            return;
         end
         e = pending_rsp.pop_front();
         if (a != e) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch exp face=%0d nx=%h ny=%h fx=%h fy=%h bad=%0d",
                         " | got face=%0d nx=%h ny=%h fx=%h fy=%h bad=%0d"},
                        e.face, e.nx, e.ny, e.fx, e.fy, e.bad,
                        a.face, a.nx, a.ny, a.fx, a.fy, a.bad);
         end
      endfunction
   endclass

   logic clock = 0, reset;
   logic req_valid, req_ready, req_kind;
   logic [13:0] req_pixel_x, req_pixel_y;
   logic [FACE_W-1:0] req_face_in;
   logic [15:0] req_norm_x_in, req_norm_y_in;
   logic rsp_valid, rsp_ready;
   logic [FACE_W-1:0] rsp_face_id;
   logic [15:0] rsp_norm_x_out, rsp_norm_y_out;
   logic [21:0] rsp_frame_x, rsp_frame_y;
   logic rsp_bad_face;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   face_map_scoreboard sb = new();
   bit idle_on;
   bit long_hold_go;
   int hold_left, stall_left;

   cube_map_pixel_face_mapper_core DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // sampled at the edge, before any of this edge's updates land
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_req('{req_kind, req_pixel_x, req_pixel_y, req_face_in,
                          req_norm_x_in, req_norm_y_in});
         if (rsp_valid && rsp_ready)
            sb.check_rsp('{rsp_face_id, rsp_norm_x_out, rsp_norm_y_out,
                           rsp_frame_x, rsp_frame_y, rsp_bad_face});
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   always @(posedge clock) begin
      if (long_hold_go) begin
         long_hold_go = 0;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else if (!idle_on) begin
         rsp_ready <= 1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = int'($urandom_range(0, 12));
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
      end
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic send_beat(map_req_t r);
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= r.kind;
      req_pixel_x <= r.px;
      req_pixel_y <= r.py;
      req_face_in <= r.face;
      req_norm_x_in <= r.nx;
      req_norm_y_in <= r.ny;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic program_geom(bit [47:0] wa, bit [47:0] wb, bit [47:0] ha,
                               bit [47:0] hb, bit [13:0] mc, bit [13:0] mr);
      bit [47:0] vals [6];
      vals = '{wa, wb, ha, hb, 48'(mc), 48'(mr)};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1;
         csr_index <= CSR_IDX_W'(i);
         // upper bits of the narrow registers get junk, which must be ignored
         csr_wdata <= i >= 4 ? {$urandom, 16'(vals[i])} & 48'hFFFF_FFFF_FFFF
                             : vals[i];
         sb.set_reg(CSR_IDX_W'(i), vals[i]);
         @(posedge clock);
      end
      csr_we <= 0;
   endtask

   function automatic bit [15:0] pick_size();
      case ($urandom_range(0, 19))
         0:       return 16'd0;
         1:       return 16'd1;
         2:       return 16'hFFFF;
         3:       return 16'($urandom_range(2000, 16383));
         default: return 16'($urandom_range(2, 700));
      endcase
   endfunction

   function automatic bit [47:0] pick_table();
      return {pick_size(), pick_size(), pick_size()};
   endfunction

   function automatic bit [13:0] pick_mid();
      case ($urandom_range(0, 9))
         0:       return 14'd0;
         1:       return 14'h3FFF;
         default: return 14'($urandom_range(0, 900));
      endcase
   endfunction

   function automatic bit [15:0] pick_norm();
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic map_req_t pick_req();
      map_req_t r;
      longint unsigned w, h;
      r.kind = 1'($urandom);
      r.face = 3'($urandom_range(0, 7));
      r.nx = pick_norm();
      r.ny = pick_norm();
      w = sb.frame_w();
      h = sb.frame_h();
      if ($urandom_range(0, 4) == 0) begin
         r.px = 14'($urandom);
         r.py = 14'($urandom);
      end else begin
         r.px = 14'($urandom_range(0, 32'(w > 16383 ? 16383 : w)));
         r.py = 14'($urandom_range(0, 32'(h > 16383 ? 16383 : h)));
      end
      return r;
   endfunction

   initial begin
      map_req_t r;
      reset <= 1;
      req_valid <= 0; req_kind <= 0; req_pixel_x <= 0; req_pixel_y <= 0;
      req_face_in <= 0; req_norm_x_in <= 0; req_norm_y_in <= 0;
      csr_we <= 0; csr_index <= 0; csr_wdata <= 0;
      idle_on = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset geometry: corners and edges of each face, black gaps
      send_beat('{0, 0, 0, 0, 0, 0});
      send_beat('{0, 14'h3FFF, 14'h3FFF, 0, 0, 0});
      send_beat('{0, 1024, 0, 0, 0, 0});
      send_beat('{0, 0, 1024, 0, 0, 0});
      send_beat('{0, 2047, 2047, 0, 0, 0});
      send_beat('{0, 1024, 2048, 0, 0, 0});
      send_beat('{0, 2048, 1024, 0, 0, 0});
      send_beat('{0, 4095, 2047, 0, 0, 0});
      send_beat('{0, 4096, 1024, 0, 0, 0});
      for (int f = 0; f < 8; f++) begin
         send_beat('{1, 0, 0, 3'(f), 16'h0000, 16'hFFFF});
         send_beat('{1, 0, 0, 3'(f), 16'hFFFF, 16'h8000});
      end
      drain();

      // degenerate sizes: empty faces, then faces larger than their spans
      program_geom(0, 0, 0, 0, 0, 0);
      send_beat('{0, 0, 0, 0, 0, 0});
      send_beat('{1, 0, 0, FACE_FRONT, 16'h8000, 16'hFFFF});
      drain();
      program_geom({3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'hFFFF}},
                   14'h3FFF, 14'h3FFF);
      send_beat('{0, 14'h3FFF, 14'h3FFF, 0, 0, 0});
      send_beat('{1, 0, 0, FACE_BACK, 16'hFFFF, 16'hFFFF});
      send_beat('{1, 0, 0, FACE_BOTTOM, 16'h1234, 16'hFFFF});
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         if (ph == 0)
            program_geom(48'h0200_0100_0180, 48'h00C0_0300_0280,
                         48'h0100_0180_0200, 48'h0080_00C0_0100, 14'd512, 14'd384);
         else
            program_geom(pick_table(), pick_table(), pick_table(), pick_table(),
                         pick_mid(), pick_mid());
         idle_on = ph < 9 && ph != 4;
         for (int i = 0; i < 193; i++) begin
            if (ph == 2 && i == 20) long_hold_go = 1;
            if (ph == 3 && i == 100) begin
               req_valid <= 0;
               while (sb.pending_rsp.size() != 0) @(posedge clock);
            end
            r = pick_req();
            send_beat(r);
         end
         drain();
      end

      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
